// ===== hw/rtl/gpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types and character constants for the GGA position extractor.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned CommaW = 3;

  localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CH_G      = 8'h47;
  localparam logic [ByteW-1:0] CH_P      = 8'h50;
  localparam logic [ByteW-1:0] CH_A      = 8'h41;
  localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] CH_MARK   = 8'h67;  // 'g' record start
  localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF     = 8'h0A;

  localparam logic [CountW-1:0] MAX_PAYLOAD_RST = 8'd25;

  // second payload comma is kept, fourth one ends the record
  localparam logic [CommaW-1:0] COMMA_KEEP = 3'd2;
  localparam logic [CommaW-1:0] COMMA_END  = 3'd4;

  // prefix match states, then skip to comma, then payload
  typedef enum logic [8:0] {
    PH_DLR     = 9'b000000001,
    PH_G1      = 9'b000000010,
    PH_P       = 9'b000000100,
    PH_G2      = 9'b000001000,
    PH_G3      = 9'b000010000,
    PH_A       = 9'b000100000,
    PH_COMMA   = 9'b001000000,
    PH_SKIP    = 9'b010000000,
    PH_PAYLOAD = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             ovf;
  } res_t;

  // expected character of "$GPGGA," in each match state
  function automatic logic [ByteW-1:0] prefix_char(input phase_t ph);
    logic [ByteW-1:0] c;
    c = CH_DOLLAR;
    unique case (ph)
      PH_DLR:                 c = CH_DOLLAR;
      PH_G1, PH_G2, PH_G3:    c = CH_G;
      PH_P:                   c = CH_P;
      PH_A:                   c = CH_A;
      PH_COMMA:               c = CH_COMMA;
      default:                c = CH_DOLLAR;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/gga_position_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gga_position_extractor
// Pulls latitude/longitude fields out of a GGA sentence byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/rx_byte): one received character per
//   word. Output channel (out_valid/out_ready/out_byte/record_end/overflow):
//   'g' when a record starts, the kept payload characters, then CR and LF;
//   record_end marks the LF, overflow on that LF says payload was dropped.
//   Config channel (cfg_valid/cfg_ready/max_payload): write the payload
//   limit while idle; cfg_ready is always high.
// Timing:
//   A word lands in the input register, is parsed combinationally and its
//   results (0, 1 or 2 words) are loaded into a two-entry result queue.
//   The first output word is driven from the queue head q0. One word per cycle
//   is sustained while out_ready stays high; the CR/LF pair at a record end
//   holds the following input word in the input register until CR is popped.
// Reset: parser back to hunting for '$', queue empty, limit set to 25.
// Stall: a blocked output holds its queued words, the input register then
//   holds its word and in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module gga_position_extractor #(
  parameter logic [gpe_pkg::CountW-1:0] MaxPayloadRst = gpe_pkg::MAX_PAYLOAD_RST
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gpe_pkg::CountW-1:0]  max_payload,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gpe_pkg::ByteW-1:0]   rx_byte,
  // output words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gpe_pkg::ByteW-1:0]   out_byte,
  output logic                        record_end,
  output logic                        overflow
);

  // payload limit register
  logic [gpe_pkg::CountW-1:0] limit;

  // input register
  logic                      r_valid;
  logic [gpe_pkg::ByteW-1:0] r_byte;

  // parser state
  gpe_pkg::phase_t             phase, phase_next;
  logic [gpe_pkg::CommaW-1:0]  comma_count, comma_count_next;
  logic [gpe_pkg::CountW-1:0]  payload_count, payload_count_next;
  logic                        dropped, dropped_next;

  // result queue, head in q0
  gpe_pkg::res_t q0, q1;
  logic [1:0]    q_cnt;

  gpe_pkg::res_t res0, res1;
  logic [1:0]    n_res;
  logic [gpe_pkg::CommaW-1:0] comma_inc;
  logic pop, space, consume;

  assign cfg_ready = 1'b1;

  assign out_valid  = (q_cnt != 2'd0);
  assign out_byte   = q0.data;
  assign record_end = q0.last;
  assign overflow   = q0.ovf;

  assign pop = out_valid && out_ready;
  // an item may load the queue only if it is empty after this cycle's pop
  assign space   = (q_cnt == 2'd0) || ((q_cnt == 2'd1) && out_ready);
  assign consume = r_valid && space;
  assign in_ready = !r_valid || consume;

  assign comma_inc = comma_count + gpe_pkg::CommaW'(1);

  // combinational parse of the word in the input register
  always_comb begin
    phase_next         = phase;
    comma_count_next   = comma_count;
    payload_count_next = payload_count;
    dropped_next       = dropped;
    n_res              = 2'd0;
    res0               = '{data: r_byte, last: 1'b0, ovf: 1'b0};
    res1               = '{data: gpe_pkg::CH_LF, last: 1'b1, ovf: dropped};
    unique case (phase)
      gpe_pkg::PH_DLR, gpe_pkg::PH_G1, gpe_pkg::PH_P, gpe_pkg::PH_G2,
      gpe_pkg::PH_G3, gpe_pkg::PH_A, gpe_pkg::PH_COMMA: begin
        // mismatching byte is consumed, not re-checked as '$'
        if (r_byte == gpe_pkg::prefix_char(phase)) begin
          phase_next = gpe_pkg::phase_t'({phase[7:0], 1'b0});
        end else begin
          phase_next = gpe_pkg::PH_DLR;
        end
      end
      gpe_pkg::PH_SKIP: begin
        if (r_byte == gpe_pkg::CH_COMMA) begin
          phase_next         = gpe_pkg::PH_PAYLOAD;
          comma_count_next   = '0;
          payload_count_next = '0;
          dropped_next       = 1'b0;
          n_res              = 2'd1;
          res0.data          = gpe_pkg::CH_MARK;
        end
      end
      gpe_pkg::PH_PAYLOAD: begin
        if (r_byte == gpe_pkg::CH_COMMA) begin
          comma_count_next = comma_inc;
        end
        if ((r_byte != gpe_pkg::CH_COMMA) || (comma_inc == gpe_pkg::COMMA_KEEP)) begin
          if (payload_count >= limit) begin
            dropped_next = 1'b1;
          end else begin
            payload_count_next = payload_count + gpe_pkg::CountW'(1);
            n_res              = 2'd1;
          end
        end else if (comma_inc >= gpe_pkg::COMMA_END) begin
          // record close: CR then LF
          phase_next         = gpe_pkg::PH_DLR;
          comma_count_next   = '0;
          payload_count_next = '0;
          dropped_next       = 1'b0;
          n_res              = 2'd2;
          res0.data          = gpe_pkg::CH_CR;
        end
      end
      default: begin
        phase_next = gpe_pkg::PH_DLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= MaxPayloadRst;
      r_valid       <= 1'b0;
      phase         <= gpe_pkg::PH_DLR;
      comma_count   <= '0;
      payload_count <= '0;
      dropped       <= 1'b0;
      q_cnt         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= max_payload;
      end
      if (in_valid && in_ready) begin
        r_valid <= 1'b1;
      end else if (consume) begin
        r_valid <= 1'b0;
      end
      if (consume) begin
        phase         <= phase_next;
        comma_count   <= comma_count_next;
        payload_count <= payload_count_next;
        dropped       <= dropped_next;
        q_cnt         <= n_res;
      end else if (pop) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_byte <= rx_byte;
    end
    if (consume) begin
      q0 <= res0;
      q1 <= res1;
    end else if (pop) begin
      q0 <= q1;
    end
  end

`ifndef SYNTHESIS
  a_qcnt_range: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("result queue count out of range");

  a_end_is_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_end) |-> (out_byte == gpe_pkg::CH_LF))
    else $error("record end not on LF");

  a_ovf_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> record_end)
    else $error("overflow flag outside record end");

  a_comma_range: assert property (@(posedge clk) disable iff (rst)
    comma_count < gpe_pkg::COMMA_END)
    else $error("comma count past record end");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && (q_cnt == 2'd2) && (out_byte == gpe_pkg::CH_CR))
      |=> (out_valid && record_end))
    else $error("CR not followed by LF");
`endif

endmodule

// ===== sim/gga_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gga_record_checker
// Watches the config, input and output channels of the GGA position
// extractor. Keeps its own parser state, predicts the record words for
// every accepted input word and checks each output word against them.
// ----------------------------------------------------------------------------
module gga_record_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [gpe_pkg::CountW-1:0]  max_payload,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [gpe_pkg::ByteW-1:0]   rx_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [gpe_pkg::ByteW-1:0]   out_byte,
  input  logic                        record_end,
  input  logic                        overflow,
  output int                          fail_count,
  output int                          pending,
  output int                          records,
  output int                          clipped_records
);

  typedef enum logic [2:0] {
    SEEK_TAG    = 3'b001,
    SKIP_TIME   = 3'b010,
    COPY_FIELDS = 3'b100
  } scan_t;

  localparam logic [7*gpe_pkg::ByteW-1:0] GGA_TAG = {
    gpe_pkg::CH_DOLLAR, gpe_pkg::CH_G, gpe_pkg::CH_P, gpe_pkg::CH_G,
    gpe_pkg::CH_G, gpe_pkg::CH_A, gpe_pkg::CH_COMMA
  };

  scan_t                       scan;
  int                          tag_pos;
  logic [gpe_pkg::CommaW-1:0]  commas;
  logic [gpe_pkg::CountW-1:0]  kept;
  logic [gpe_pkg::CountW-1:0]  limit;
  logic                        clipped;
  gpe_pkg::res_t               record_q[$];

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 40) $display("mismatch @%0t: %s", $time, what);
  endtask

  task automatic push_word(input logic [gpe_pkg::ByteW-1:0] b, input logic last,
                           input logic ovf);
    gpe_pkg::res_t w;
    w.data = b;
    w.last = last;
    w.ovf  = ovf;
    record_q.push_back(w);
  endtask

  // payload byte, subject to the limit
  task automatic keep_char(input logic [gpe_pkg::ByteW-1:0] b);
    if (kept >= limit) begin
      clipped = 1'b1;
    end else begin
      kept++;
      push_word(b, 1'b0, 1'b0);
    end
  endtask

  task automatic predict(input logic [gpe_pkg::ByteW-1:0] b);
    unique case (scan)
      SEEK_TAG: begin
        if (b != GGA_TAG[(6-tag_pos)*gpe_pkg::ByteW +: gpe_pkg::ByteW]) begin
          tag_pos = 0;
        end else if (tag_pos == 6) begin
          tag_pos = 0;
          scan = SKIP_TIME;
        end else begin
          tag_pos++;
        end
      end
      SKIP_TIME: begin
        if (b == gpe_pkg::CH_COMMA) begin
          scan    = COPY_FIELDS;
          commas  = '0;
          kept    = '0;
          clipped = 1'b0;
          push_word(gpe_pkg::CH_MARK, 1'b0, 1'b0);
        end
      end
      default: begin
        if (b != gpe_pkg::CH_COMMA) begin
          keep_char(b);
        end else begin
          commas = commas + gpe_pkg::CommaW'(1);
          if (commas == gpe_pkg::COMMA_KEEP) begin
            keep_char(b);
          end else if (commas >= gpe_pkg::COMMA_END) begin
            push_word(gpe_pkg::CH_CR, 1'b0, 1'b0);
            push_word(gpe_pkg::CH_LF, 1'b1, clipped);
            scan    = SEEK_TAG;
            commas  = '0;
            kept    = '0;
            clipped = 1'b0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    gpe_pkg::res_t want;
    if (rst) begin
      scan            = SEEK_TAG;
      tag_pos         = 0;
      commas          = '0;
      kept            = '0;
      clipped         = 1'b0;
      limit           = gpe_pkg::MAX_PAYLOAD_RST;
      fail_count      = 0;
      records         = 0;
      clipped_records = 0;
      record_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit = max_payload;
      if (out_valid && out_ready) begin
        if (record_q.size() == 0) begin
          report($sformatf("unexpected word %02h", out_byte));
        end else begin
          want = record_q.pop_front();
          if (out_byte !== want.data)
            report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (record_end !== want.last)
            report($sformatf("record_end %b, want %b", record_end, want.last));
          if (overflow !== want.ovf)
            report($sformatf("overflow %b, want %b", overflow, want.ovf));
          if (want.last) begin
            records++;
            if (want.ovf) clipped_records++;
          end
        end
      end
      if (in_valid && in_ready) predict(rx_byte);
    end
    pending = record_q.size();
  end

endmodule

// ===== sim/tb_gga_position_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gga_position_extractor
// Feeds GGA-like byte streams into the extractor: a few directed sentences,
// then random phases of well-formed sentences, broken prefixes and noise
// under several payload limits. A checker beside the block predicts and
// compares every output word; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_gga_position_extractor;

  localparam logic [7*gpe_pkg::ByteW-1:0] GGA_TAG = {
    gpe_pkg::CH_DOLLAR, gpe_pkg::CH_G, gpe_pkg::CH_P, gpe_pkg::CH_G,
    gpe_pkg::CH_G, gpe_pkg::CH_A, gpe_pkg::CH_COMMA
  };

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [gpe_pkg::CountW-1:0]  max_payload;
  logic                        in_valid;
  logic                        in_ready;
  logic [gpe_pkg::ByteW-1:0]   rx_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [gpe_pkg::ByteW-1:0]   out_byte;
  logic                        record_end;
  logic                        overflow;

  int fail_count;
  int pending;
  int records;
  int clipped_records;

  int                        bytes_sent;
  int                        cfg_writes;
  bit                        calm;      // set for the last phase: no idling on either side
  logic [gpe_pkg::ByteW-1:0] byte_q[$]; // words waiting to be sent

  gga_position_extractor DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .max_payload(max_payload),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .record_end (record_end),
    .overflow   (overflow)
  );

  gga_record_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .max_payload    (max_payload),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .record_end     (record_end),
    .overflow       (overflow),
    .fail_count     (fail_count),
    .pending        (pending),
    .records        (records),
    .clipped_records(clipped_records)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout: run did not finish");
    $display("status: fail");
    $finish;
  end

  // Output side: ready high for random stretches, low in random bursts.
  // One assignment per falling edge at most.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  function automatic logic [gpe_pkg::ByteW-1:0] tag_char(input int i);
    return GGA_TAG[(6-i)*gpe_pkg::ByteW +: gpe_pkg::ByteW];
  endfunction

  // mostly digits and dots, sometimes any byte that is not a comma
  function automatic logic [gpe_pkg::ByteW-1:0] field_char();
    logic [gpe_pkg::ByteW-1:0] b;
    if ($urandom_range(0, 3) != 0) begin
      b = ($urandom_range(0, 10) == 10) ? 8'h2E
                                         : 8'h30 + gpe_pkg::ByteW'($urandom_range(0, 9));
    end else begin
      do b = gpe_pkg::ByteW'($urandom_range(0, 255)); while (b == gpe_pkg::CH_COMMA);
    end
    return b;
  endfunction

  // One word on the input channel. Valid rises at a falling edge, possibly
  // after an idle burst, and the word is done at the rising edge where
  // valid and ready are both high.
  task automatic send_byte(input logic [gpe_pkg::ByteW-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (byte_q[i]) send_byte(byte_q[i]);
    byte_q.delete();
  endtask

  // Block idle: input dropped, every expected word out, plus a wait
  // for words still in the input register that make no output.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [gpe_pkg::CountW-1:0] v);
    settle();
    cfg_valid   <= 1'b1;
    max_payload <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // "$GPGGA," time, lat, N/S, lon, E/W, then some trailing junk
  task automatic queue_sentence();
    for (int i = 0; i < 7; i++) byte_q.push_back(tag_char(i));
    repeat ($urandom_range(0, 9)) byte_q.push_back(field_char());
    byte_q.push_back(gpe_pkg::CH_COMMA);
    repeat ($urandom_range(0, 12)) byte_q.push_back(field_char());
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back($urandom_range(0, 3) == 0 ? field_char()
                                               : ($urandom_range(0, 1) ? "N" : "S"));
    byte_q.push_back(gpe_pkg::CH_COMMA);
    repeat ($urandom_range(0, 12)) byte_q.push_back(field_char());
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back($urandom_range(0, 3) == 0 ? field_char()
                                               : ($urandom_range(0, 1) ? "E" : "W"));
    byte_q.push_back(gpe_pkg::CH_COMMA);
    repeat ($urandom_range(0, 6)) byte_q.push_back(gpe_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // prefix broken at a random spot, then the rest of it and a run of commas
  task automatic queue_broken();
    int cut;
    logic [gpe_pkg::ByteW-1:0] bad;
    cut = $urandom_range(0, 6);
    for (int i = 0; i < cut; i++) byte_q.push_back(tag_char(i));
    if (cut > 0 && $urandom_range(0, 1)) begin
      bad = gpe_pkg::CH_DOLLAR;
    end else begin
      do bad = gpe_pkg::ByteW'($urandom_range(0, 255)); while (bad == tag_char(cut));
    end
    byte_q.push_back(bad);
    for (int i = cut; i < 7; i++) byte_q.push_back(tag_char(i));
    repeat (5) byte_q.push_back(gpe_pkg::CH_COMMA);
  endtask

  task automatic random_phase(input logic [gpe_pkg::CountW-1:0] lim, input int n);
    int stop;
    int pick;
    write_limit(lim);
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_sentence();
      end else if (pick < 9) begin
        queue_broken();
      end else begin
        repeat ($urandom_range(1, 10))
          byte_q.push_back(gpe_pkg::ByteW'($urandom_range(0, 255)));
      end
      send_queued();
    end
  endtask

  initial begin : stimulus
    int guard;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    max_payload = '0;
    in_valid    = 1'b0;
    rx_byte     = '0;
    calm        = 1'b0;
    bytes_sent  = 0;
    cfg_writes  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset limit of 25.
    // A '$' that breaks the prefix is used up: "$G$GPGGA,," must stay quiet.
    byte_q.push_back(gpe_pkg::CH_DOLLAR);
    byte_q.push_back(gpe_pkg::CH_G);
    for (int i = 0; i < 7; i++) byte_q.push_back(tag_char(i));
    byte_q.push_back(gpe_pkg::CH_COMMA);
    // Comma right after the prefix ends the skip at once; payload holds
    // 0x00, 0xFF and '$' as plain data, second comma kept, fourth ends.
    for (int i = 0; i < 7; i++) byte_q.push_back(tag_char(i));
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back(8'h00);
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back(8'hFF);
    byte_q.push_back(gpe_pkg::CH_DOLLAR);
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back(gpe_pkg::CH_COMMA);
    byte_q.push_back(gpe_pkg::CH_COMMA);
    send_queued();

    // Random phases: limit extremes first, then assorted small limits so
    // records overflow often. The last phase runs with no idling.
    random_phase(8'd255, 260);
    random_phase(8'd1, 260);
    random_phase(gpe_pkg::CountW'($urandom_range(2, 30)), 260);
    random_phase(gpe_pkg::CountW'($urandom_range(1, 12)), 260);
    calm = 1'b1;
    random_phase(gpe_pkg::CountW'($urandom_range(20, 30)), 260);

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);

    $display("covered: %0d input words, %0d limit writes", bytes_sent, cfg_writes);
    $display("covered: %0d records closed, %0d with dropped payload", records, clipped_records);
    if (pending != 0) $display("%0d expected words never came out", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
